### src/dtrag_pkg.sv
// ----------------------------------------------------------------------------
// dtrag_pkg
// shared widths, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package dtrag_pkg;

  // tile edge in pixels
  localparam int TILE_SIZE = 16;

  // frame geometry
  localparam int DIM_W   = 13;
  localparam int DIM_MAX = 4096;
  localparam int PB_W    = 3;
  localparam int PB_MAX  = 4;

  // transaction fields
  localparam int TILE_W  = 16;
  localparam int SLOT_W  = 12;
  localparam int BATCH_W = 13;
  localparam int DEST_W  = 26;
  localparam int SRC_W   = 27;
  localparam int RB_W    = 9;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  // derived tile grid sizes
  localparam int MAX_GRID = (DIM_MAX - 1) / TILE_SIZE + 1;
  localparam int GRID_W   = $clog2(MAX_GRID + 1);
  localparam int IDX_W    = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int ROW_W    = $clog2(TILE_SIZE + 1);
  localparam int PIX_W    = $clog2(DIM_MAX);
  localparam int LB_W     = DIM_W + PB_W;
  localparam int STEP_W   = $clog2(TILE_W);

  // configuration port
  localparam int REG_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PIXEL_BYTES  = 2'd2;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd768;
  localparam logic [PB_W-1:0]  RST_PIXEL_BYTES  = 3'd4;

  // clamped configuration
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [PB_W-1:0]  pbytes;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mul1;
    logic mul2;
    logic emit_row;
    logic emit_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic batch_zero;
    logic idx_err;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

### src/dtrag_cfg.sv
// ----------------------------------------------------------------------------
// dtrag_cfg
// apb register file for frame geometry, with clamped values for the datapath
// ----------------------------------------------------------------------------
module dtrag_cfg
  import dtrag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [DIM_W-1:0]     width_q, width_d;
  logic [DIM_W-1:0]     height_q, height_d;
  logic [PB_W-1:0]      pbytes_q, pbytes_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    pbytes_d = pbytes_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_d  = pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: height_d = pwdata[DIM_W-1:0];
        REG_PIXEL_BYTES:  pbytes_d = pwdata[PB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME_WIDTH;
      height_q <= RST_FRAME_HEIGHT;
      pbytes_q <= RST_PIXEL_BYTES;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      pbytes_q <= pbytes_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, width_q};
      REG_FRAME_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, height_q};
      REG_PIXEL_BYTES:  prdata = {{(APB_DATA_W-PB_W){1'b0}}, pbytes_q};
      default:          prdata = '0;
    endcase
  end

  // saturate to the legal ranges
  always_comb begin
    if (width_q == '0) cfg_o.width = DIM_W'(1);
    else if (width_q > DIM_W'(DIM_MAX)) cfg_o.width = DIM_W'(DIM_MAX);
    else cfg_o.width = width_q;

    if (height_q == '0) cfg_o.height = DIM_W'(1);
    else if (height_q > DIM_W'(DIM_MAX)) cfg_o.height = DIM_W'(DIM_MAX);
    else cfg_o.height = height_q;

    if (pbytes_q == '0) cfg_o.pbytes = PB_W'(1);
    else if (pbytes_q > PB_W'(PB_MAX)) cfg_o.pbytes = PB_W'(PB_MAX);
    else cfg_o.pbytes = pbytes_q;
  end

endmodule

### src/dtrag_datapath.sv
// ----------------------------------------------------------------------------
// dtrag_datapath
// grid check, bit-serial index divider, address setup and row output register
// ----------------------------------------------------------------------------
module dtrag_datapath
  import dtrag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic [TILE_W-1:0]  tile_index_i,
  input  logic [SLOT_W-1:0]  batch_slot_i,
  input  logic [BATCH_W-1:0] batch_tiles_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [DEST_W-1:0]  dest_address_o,
  output logic [SRC_W-1:0]   source_offset_o,
  output logic [RB_W-1:0]    row_bytes_o,
  output logic               last_row_o,
  output logic               index_error_o
);

  logic [TILE_W-1:0]  tile_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [BATCH_W-1:0] batch_q;

  // divider: quotient shifts in where the dividend shifts out
  logic [TILE_W-1:0]  dq_q, dq_d;
  logic [GRID_W-1:0]  rem_q, rem_d;
  logic [GRID_W:0]    rem_sh, rem_sub;
  logic               rem_ge;

  logic [GRID_W-1:0]  cols, rows;
  logic [DIM_W-1:0]   wm1, hm1;
  logic [2*GRID_W-1:0] grid;

  logic [IDX_W-1:0]   tcol, trow;
  logic [PIX_W-1:0]   left, top;
  logic [ROW_W-1:0]   tw, th;

  logic [PIX_W-1:0]   top_q;
  logic [ROW_W-1:0]   th_q;
  logic [ROW_W-1:0]   r_q;
  logic [RB_W-1:0]    rb_q;
  logic [LB_W-1:0]    line_q;
  logic [DEST_W-1:0]  leftpb_q;
  logic [SRC_W-1:0]   stride_q;
  logic [DEST_W-1:0]  dest_q;
  logic [SRC_W-1:0]   src_q;
  logic               last_row;
  logic               out_valid_q;

  // grid dimensions from the clamped frame size
  assign wm1  = cfg_i.width - DIM_W'(1);
  assign hm1  = cfg_i.height - DIM_W'(1);
  assign cols = GRID_W'(wm1 / TILE_SIZE) + GRID_W'(1);
  assign rows = GRID_W'(hm1 / TILE_SIZE) + GRID_W'(1);
  assign grid = (2*GRID_W)'(cols) * (2*GRID_W)'(rows);

  assign rem_sh  = {rem_q, dq_q[TILE_W-1]};
  assign rem_sub = rem_sh - {1'b0, cols};
  assign rem_ge  = (rem_sh >= {1'b0, cols});
  assign rem_d   = rem_ge ? rem_sub[GRID_W-1:0] : rem_sh[GRID_W-1:0];
  assign dq_d    = {dq_q[TILE_W-2:0], rem_ge};

  // after the last divide step
  assign tcol = rem_q[IDX_W-1:0];
  assign trow = dq_q[IDX_W-1:0];
  assign left = PIX_W'(tcol * TILE_SIZE);
  assign top  = PIX_W'(trow * TILE_SIZE);
  assign tw   = (GRID_W'(tcol) == cols - GRID_W'(1)) ?
                ROW_W'(cfg_i.width - DIM_W'(left)) : ROW_W'(TILE_SIZE);
  assign th   = (GRID_W'(trow) == rows - GRID_W'(1)) ?
                ROW_W'(cfg_i.height - DIM_W'(top)) : ROW_W'(TILE_SIZE);

  assign last_row = (r_q == th_q - ROW_W'(1));

  assign status_o.batch_zero = (batch_tiles_i == '0);
  assign status_o.idx_err    = (32'(tile_q) >= 32'(grid));
  assign status_o.last_row   = last_row;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tile_q  <= tile_index_i;
      slot_q  <= batch_slot_i;
      batch_q <= batch_tiles_i;
      dq_q    <= tile_index_i;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
    if (cmd_i.mul1) begin
      top_q    <= top;
      th_q     <= th;
      r_q      <= '0;
      rb_q     <= RB_W'(RB_W'(tw) * RB_W'(cfg_i.pbytes));
      line_q   <= LB_W'(cfg_i.width) * LB_W'(cfg_i.pbytes);
      leftpb_q <= DEST_W'(left) * DEST_W'(cfg_i.pbytes);
      stride_q <= SRC_W'(batch_q) * SRC_W'(cfg_i.pbytes) * SRC_W'(TILE_SIZE);
      src_q    <= SRC_W'(slot_q) * SRC_W'(cfg_i.pbytes) * SRC_W'(TILE_SIZE);
    end
    if (cmd_i.mul2) begin
      dest_q <= DEST_W'(top_q) * DEST_W'(line_q) + leftpb_q;
    end
    if (cmd_i.emit_row) begin
      dest_address_o  <= dest_q;
      source_offset_o <= src_q;
      row_bytes_o     <= rb_q;
      last_row_o      <= last_row;
      index_error_o   <= 1'b0;
      dest_q          <= dest_q + DEST_W'(line_q);
      src_q           <= src_q + stride_q;
      r_q             <= r_q + ROW_W'(1);
    end
    if (cmd_i.emit_err) begin
      dest_address_o  <= '0;
      source_offset_o <= '0;
      row_bytes_o     <= '0;
      last_row_o      <= 1'b1;
      index_error_o   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_row || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/dtrag_ctrl.sv
// ----------------------------------------------------------------------------
// dtrag_ctrl
// sequencer: accept, grid check, divide, address setup, row emission
// ----------------------------------------------------------------------------
module dtrag_ctrl
  import dtrag_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_ERR   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !status_i.batch_zero) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        step_d = '0;
        if (status_i.idx_err) state_d = S_ERR;
        else state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + STEP_W'(1);
        if (step_q == STEP_W'(TILE_W - 1)) state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          if (status_i.last_row) state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (status_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

### src/dirty_tile_row_address_generator_top.sv
// ----------------------------------------------------------------------------
// dirty_tile_row_address_generator_top
// turns one dirty tile entry into per-row framebuffer and strip addresses
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tile entry: tile_index, batch_slot, batch_tiles
//  m_axis   | out       | row result: dest_address, source_offset, row_bytes,
//           |           | tlast = last_row, tuser = index_error
//  apb      | in        | frame_width @0x0, frame_height @0x4, pixel_bytes @0x8
//
//  a valid tile goes through accept, grid check, the one-bit-per-cycle index
//  divider, the setup states MUL1 and MUL2, then one row per cycle unless m_axis stalls
//  an index outside the grid gets a single error result, an empty batch none
//  reset loads 1024 x 768 at 4 bytes per pixel, no clearing pass
//  results sit in an output register; a stalled m_axis holds row emission
//  while the next tile entry is taken as soon as the last row is registered
// ----------------------------------------------------------------------------
module dirty_tile_row_address_generator_top
  import dtrag_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tile entry transactions
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] tile_index, [27:16] batch_slot, [40:28] batch_tiles, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // row result transactions
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [25:0] dest_address, [52:26] source_offset, [61:53] row_bytes, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // [0] index_error
  output logic                  m_axis_tuser,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t              cfg;
  cmd_t              cmd;
  status_t           status;
  logic [DEST_W-1:0] dest_address;
  logic [SRC_W-1:0]  source_offset;
  logic [RB_W-1:0]   row_bytes;

  // register file, clamped values feed the datapath
  dtrag_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer
  dtrag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // divider, address arithmetic and output register
  dtrag_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .tile_index_i    (s_axis_tdata[TILE_W-1:0]),
    .batch_slot_i    (s_axis_tdata[TILE_W+SLOT_W-1:TILE_W]),
    .batch_tiles_i   (s_axis_tdata[TILE_W+SLOT_W+BATCH_W-1:TILE_W+SLOT_W]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .dest_address_o  (dest_address),
    .source_offset_o (source_offset),
    .row_bytes_o     (row_bytes),
    .last_row_o      (m_axis_tlast),
    .index_error_o   (m_axis_tuser)
  );

  // pack the result fields, lowest first
  assign m_axis_tdata = {{(OUT_DATA_W-DEST_W-SRC_W-RB_W){1'b0}},
                         row_bytes, source_offset, dest_address};

endmodule

### src/dtrag_checker.sv
// ----------------------------------------------------------------------------
// dtrag_checker
// port-level checks on the row address generator, bound to the top level
// ----------------------------------------------------------------------------
module dtrag_checker
  import dtrag_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // an error result is a single zeroed last row
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("index error result not zero or not last");

  // a real row always copies something
  a_row_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[61:53] != 9'd0))
    else $error("row result with zero byte count");

  // a non-empty tile entry makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[40:28] != 13'd0)
      |=> !s_axis_tready)
    else $error("ready stayed high after a tile entry");

endmodule

bind dirty_tile_row_address_generator_top dtrag_checker u_dtrag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

### dv/dirty_tile_row_address_generator_top_tb.sv
// ----------------------------------------------------------------------------
// dirty_tile_row_address_generator_top_tb
// self-checking bench: tile entries in, per-row framebuffer and strip
// addresses out, predicted row by row and compared in order under random
// stalls on both streams and a series of frame geometries set over apb
// ----------------------------------------------------------------------------
module dirty_tile_row_address_generator_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import dtrag_pkg::*;

  // no register lives at this index, writes to it must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int CYCLE_LIMIT   = 500000;
  // settle time after a drain, long enough for any tile still in flight
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TILES   = 60;

  typedef struct {
    logic [TILE_W-1:0]  tile_index;
    logic [SLOT_W-1:0]  batch_slot;
    logic [BATCH_W-1:0] batch_tiles;
    bit                 drain_first;  // hold back until all rows are back
  } tile_entry_t;

  typedef struct {
    logic [DEST_W-1:0] dest_address;
    logic [SRC_W-1:0]  source_offset;
    logic [RB_W-1:0]   row_bytes;
    logic              last_row;
    logic              index_error;
  } row_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [15:0] tile_index, [27:16] batch_slot, [40:28] batch_tiles, rest zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [25:0] dest_address, [52:26] source_offset, [61:53] row_bytes, rest zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  // [0] index_error
  logic                  m_axis_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [REG_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // register shadow, kept as written (masked to width, not yet clamped)
  logic [DIM_W-1:0] frame_width_q  = RST_FRAME_WIDTH;
  logic [DIM_W-1:0] frame_height_q = RST_FRAME_HEIGHT;
  logic [PB_W-1:0]  pixel_bytes_q  = RST_PIXEL_BYTES;

  tile_entry_t tile_entry_q[$];
  row_result_t row_result_q[$];
  tile_entry_t cur_entry;
  bit          entry_busy = 1'b0;
  int unsigned tiles_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;

  // a stretch of the run where neither side ever stalls
  wire calm_stretch = (tiles_sent >= 180) && (tiles_sent < 280);

  dirty_tile_row_address_generator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                              int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // effective geometry: saturated registers and the tile grid they span
  function automatic void tile_grid(output int unsigned w, output int unsigned h,
                                    output int unsigned pb, output int unsigned cols,
                                    output int unsigned rows);
    w    = clamp_range(frame_width_q, 1, DIM_MAX);
    h    = clamp_range(frame_height_q, 1, DIM_MAX);
    pb   = clamp_range(pixel_bytes_q, 1, PB_MAX);
    cols = (w - 1) / TILE_SIZE + 1;
    rows = (h - 1) / TILE_SIZE + 1;
  endfunction

  // expected row transactions for one accepted tile entry
  function automatic void predict_rows(tile_entry_t e);
    int unsigned w, h, pb, cols, rows, trow, tcol, left, top, tw, th;
    longint unsigned dest, src;
    row_result_t row;
    if (e.batch_tiles == 0) return;
    tile_grid(w, h, pb, cols, rows);
    if (e.tile_index >= cols * rows) begin
      row = '{dest_address: '0, source_offset: '0, row_bytes: '0,
              last_row: 1'b1, index_error: 1'b1};
      row_result_q.push_back(row);
      return;
    end
    trow = e.tile_index / cols;
    tcol = e.tile_index % cols;
    left = tcol * TILE_SIZE;
    top  = trow * TILE_SIZE;
    // last grid column and row are clipped at the frame edge
    tw   = (tcol == cols - 1) ? w - left : TILE_SIZE;
    th   = (trow == rows - 1) ? h - top : TILE_SIZE;
    for (int unsigned r = 0; r < th; r++) begin
      dest = longint'(top + r) * w * pb + left * pb;
      src  = longint'(r) * e.batch_tiles * TILE_SIZE * pb
           + longint'(e.batch_slot) * TILE_SIZE * pb;
      row.dest_address  = DEST_W'(dest);
      row.source_offset = SRC_W'(src);
      row.row_bytes     = RB_W'(tw * pb);
      row.last_row      = (r == th - 1);
      row.index_error   = 1'b0;
      row_result_q.push_back(row);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tile entry driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (entry_busy && s_axis_tready) begin
        predict_rows(cur_entry);
        entry_busy = 1'b0;
        tiles_sent++;
      end
      if (!entry_busy && tile_entry_q.size() != 0 &&
          (calm_stretch || $urandom_range(99) >= 22) &&
          !(tile_entry_q[0].drain_first && row_result_q.size() != 0)) begin
        cur_entry = tile_entry_q.pop_front();
        entry_busy = 1'b1;
        s_axis_tdata <= {{(IN_DATA_W - TILE_W - SLOT_W - BATCH_W){1'b0}},
                         cur_entry.batch_tiles, cur_entry.batch_slot,
                         cur_entry.tile_index};
      end
      s_axis_tvalid <= entry_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // row result sink and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && (calm_stretch || $urandom_range(99) >= 22);
  end

  always @(posedge clk_i) begin : check_rows
    row_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (row_result_q.size() == 0) begin
        $error("row transaction with nothing expected: dest_address %0d",
               m_axis_tdata[DEST_W-1:0]);
        fail_count++;
      end else begin
        want = row_result_q.pop_front();
        check_field("dest_address", want.dest_address, m_axis_tdata[DEST_W-1:0]);
        check_field("source_offset", want.source_offset,
                    m_axis_tdata[DEST_W+SRC_W-1:DEST_W]);
        check_field("row_bytes", want.row_bytes,
                    m_axis_tdata[DEST_W+SRC_W+RB_W-1:DEST_W+SRC_W]);
        check_field("tdata padding", 0, m_axis_tdata[OUT_DATA_W-1:DEST_W+SRC_W+RB_W]);
        check_field("last_row", want.last_row, m_axis_tlast);
        check_field("index_error", want.index_error, m_axis_tuser);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dirty_tile_row_address_generator_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // setup then access phase; the register takes the value at the access edge
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FRAME_WIDTH:  frame_width_q  = value[DIM_W-1:0];
      REG_FRAME_HEIGHT: frame_height_q = value[DIM_W-1:0];
      REG_PIXEL_BYTES:  pixel_bytes_q  = value[PB_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_tile(int unsigned tile, int unsigned slot, int unsigned batch,
                            bit drain = 1'b0);
    tile_entry_t e;
    e.tile_index  = TILE_W'(tile);
    e.batch_slot  = SLOT_W'(slot);
    e.batch_tiles = BATCH_W'(batch);
    e.drain_first = drain;
    tile_entry_q.push_back(e);
  endtask

  // mostly in-grid tiles, biased toward the clipped edges, some wild indexes
  task automatic queue_random_tile();
    int unsigned w, h, pb, cols, rows, tile, batch, pick;
    tile_grid(w, h, pb, cols, rows);
    pick = $urandom_range(99);
    if (pick < 8)
      tile = $urandom_range(0, 65535);
    else if (pick < 20)
      tile = $urandom_range(0, rows - 1) * cols + cols - 1;
    else if (pick < 30)
      tile = (rows - 1) * cols + $urandom_range(0, cols - 1);
    else
      tile = $urandom_range(0, cols * rows - 1);
    pick = $urandom_range(99);
    if (pick < 4)       batch = 0;
    else if (pick < 40) batch = $urandom_range(1, 8);
    else if (pick < 48) batch = 8191;
    else                batch = $urandom_range(1, 8191);
    queue_tile(tile, $urandom_range(0, 4095), batch, $urandom_range(59) == 0);
  endtask

  function automatic logic [APB_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 8191;
      2: return DIM_MAX;
      3: return 1;
      4: return $urandom();  // junk above the register width
      default: return $urandom_range(1, DIM_MAX);
    endcase
  endfunction

  // all entries taken, all rows back, then let any empty-batch entry settle
  task automatic drain_idle();
    do @(posedge clk_i);
    while (tile_entry_q.size() != 0 || entry_busy || row_result_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry 1024 x 768, 4 bytes: 64 x 48 grid
    queue_tile(0, 0, 1);
    queue_tile(63, 1, 2);
    queue_tile(3071, 4095, 8191);
    queue_tile(3072, 5, 3);           // just past the grid
    queue_tile(65535, 0, 1);
    queue_tile(10, 0, 0);             // empty batch
    queue_tile(65535, 7, 0);          // empty batch wins over a bad index
    queue_tile(100, 4000, 2, 1'b1);   // slot past the batch, after a full drain
    drain_idle();

    // 1000 x 700, 3 bytes: last column 8 wide, last row 12 high
    write_reg(REG_FRAME_WIDTH, 1000);
    write_reg(REG_FRAME_HEIGHT, 700);
    write_reg(REG_PIXEL_BYTES, 3);
    queue_tile(62, 0, 4);
    queue_tile(2709, 1, 4);
    queue_tile(2771, 2, 4);
    queue_tile(2772, 0, 4);
    drain_idle();

    // zero registers saturate up to a single one-pixel tile
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    write_reg(REG_PIXEL_BYTES, 0);
    queue_tile(0, 4095, 8191);
    queue_tile(1, 0, 1);
    drain_idle();

    // all-ones registers saturate down to 4096 x 4096 at 4 bytes
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    write_reg(REG_FRAME_HEIGHT, 8191);
    write_reg(REG_PIXEL_BYTES, 7);
    queue_tile(65535, 4095, 8191);
    queue_tile(0, 0, 8191);
    queue_tile(255, 0, 1);
    drain_idle();

    // two columns, the second one pixel wide, and a write to no register
    write_reg(REG_FRAME_WIDTH, 17);
    write_reg(REG_FRAME_HEIGHT, DIM_MAX);
    write_reg(REG_PIXEL_BYTES, 2);
    write_reg(REG_SPARE, 32'h0000_0055);
    queue_tile(1, 3, 5);
    queue_tile(511, 0, 1);
    queue_tile(512, 0, 1);
    drain_idle();

    // one column, second row one pixel high, oversized pixel bytes
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 17);
    write_reg(REG_PIXEL_BYTES, 5);
    queue_tile(1, 0, 1);
    queue_tile(0, 1, 1);
    queue_tile(2, 0, 1);
    drain_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(REG_FRAME_WIDTH, pick_dim());
      write_reg(REG_FRAME_HEIGHT, pick_dim());
      write_reg(REG_PIXEL_BYTES,
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, PB_MAX));
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
      for (int i = 0; i < PHASE_TILES; i++) queue_random_tile();
      drain_idle();
    end

    if (row_result_q.size() != 0) begin
      $error("%0d row transactions never arrived", row_result_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("dirty_tile_row_address_generator_top regression: pass");
    end else begin
      $display("dirty_tile_row_address_generator_top regression: fail");
    end
    $finish;
  end

endmodule
